>>> rtl/scd_pkg.sv
`default_nettype none

package scd_pkg;

  localparam int ADDR_W         = 32;
  localparam int DEF_SETS       = 64;
  localparam int DEF_WAYS       = 4;
  localparam int DEF_LINE_BYTES = 64;
  localparam int WAY_OUT_W      = 2;
  localparam int LFSR_W         = 16;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  typedef enum logic [1:0] {
    REQ_READ    = 2'd0,
    REQ_WRITE   = 2'd1,
    REQ_INVAL   = 2'd2,
    REQ_INSTALL = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } dir_state_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic                 fetch_line;
    logic                 writeback;
    logic [ADDR_W-1:0]    writeback_address;
    logic                 evicted;
  } result_t;

  // update decision handed from the set logic to the directory control
  typedef struct packed {
    logic    wr_en;
    logic    lfsr_step;
    result_t rsp;
  } set_update_t;

endpackage

`default_nettype wire

>>> rtl/scd_if.sv
`default_nettype none

interface scd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] address;

  modport source (output valid, output req_type, output address, input ready);
  modport sink   (input valid, input req_type, input address, output ready);
endinterface

interface scd_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [1:0]  way;
  logic        fetch_line;
  logic        writeback;
  logic [31:0] writeback_address;
  logic        evicted;

  modport source (output valid, output hit, output way, output fetch_line,
                  output writeback, output writeback_address, output evicted,
                  input ready);
  modport sink   (input valid, input hit, input way, input fetch_line,
                  input writeback, input writeback_address, input evicted,
                  output ready);
endinterface

interface scd_cfg_if;
  logic valid;
  logic ready;
  logic replacement_mode;

  modport source (output valid, output replacement_mode, input ready);
  modport sink   (input valid, input replacement_mode, output ready);
endinterface

`default_nettype wire

>>> rtl/scd_set_update.sv
`default_nettype none

module scd_set_update #(
  parameter int SETS       = scd_pkg::DEF_SETS,
  parameter int WAYS       = scd_pkg::DEF_WAYS,
  parameter int LINE_BYTES = scd_pkg::DEF_LINE_BYTES,
  parameter int OFF_BITS   = $clog2(LINE_BYTES),
  parameter int IDX_BITS   = $clog2(SETS),
  parameter int IDX_W      = (IDX_BITS > 0) ? IDX_BITS : 1,
  parameter int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1,
  parameter int TAG_W      = scd_pkg::ADDR_W - OFF_BITS - IDX_BITS
) (
  input  var scd_pkg::req_kind_t           kind,
  input  var logic [TAG_W-1:0]             tag,
  input  var logic [IDX_W-1:0]             index,
  input  var logic                         mode,
  input  var logic [scd_pkg::LFSR_W-1:0]   lfsr,
  input  var logic [WAYS-1:0]              valid_in,
  input  var logic [WAYS-1:0]              dirty_in,
  input  var logic [WAYS*TAG_W-1:0]        tags_in,
  input  var logic [WAYS*WAY_W-1:0]        ages_in,
  output var logic [WAYS-1:0]              valid_out,
  output var logic [WAYS-1:0]              dirty_out,
  output var logic [WAYS*TAG_W-1:0]        tags_out,
  output var logic [WAYS*WAY_W-1:0]        ages_out,
  output var scd_pkg::set_update_t         upd
);
  import scd_pkg::*;

  localparam int AGE_W = WAY_W;

  logic             hit_found;
  logic [WAY_W-1:0] hit_way;
  logic             free_found;
  logic [WAY_W-1:0] free_way;
  logic [WAY_W-1:0] lru_way;
  logic [WAY_W-1:0] rand_way;

  // tag match, first invalid way and oldest way, all lowest-numbered first
  always_comb begin
    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    lru_way    = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (valid_in[i] && tags_in[i*TAG_W +: TAG_W] == tag) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(i);
      end
      if (!valid_in[i]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(i);
      end
      // ages form a permutation, so the oldest way carries the top age
      if (ages_in[i*AGE_W +: AGE_W] == AGE_W'(WAYS - 1)) begin
        lru_way = WAY_W'(i);
      end
    end
    rand_way = WAY_W'(lfsr & LFSR_W'(WAYS - 1));
  end

  always_comb begin
    logic             alloc;
    logic             victim;
    logic [WAY_W-1:0] w;
    logic [AGE_W-1:0] age_w;
    logic [TAG_W-1:0] vic_tag;
    logic             touch;

    alloc     = !hit_found && kind != REQ_INVAL;
    victim    = alloc && !free_found;
    touch     = 1'b0;
    valid_out = valid_in;
    dirty_out = dirty_in;
    tags_out  = tags_in;
    ages_out  = ages_in;
    upd       = '0;

    if (hit_found) begin
      w = hit_way;
    end else if (free_found) begin
      w = free_way;
    end else if (mode) begin
      w = rand_way;
    end else begin
      w = lru_way;
    end

    age_w   = ages_in[w*AGE_W +: AGE_W];
    vic_tag = tags_in[w*TAG_W +: TAG_W];

    if (hit_found && kind == REQ_INVAL) begin
      valid_out[w] = 1'b0;
      dirty_out[w] = 1'b0;
    end else if (hit_found) begin
      if (kind != REQ_READ) begin
        dirty_out[w] = 1'b1;
      end
      touch = 1'b1;
    end else if (alloc) begin
      valid_out[w]                 = 1'b1;
      dirty_out[w]                 = (kind != REQ_READ);
      tags_out[w*TAG_W +: TAG_W]   = tag;
      touch = 1'b1;
    end

    if (touch) begin
      for (int i = 0; i < WAYS; i++) begin
        if (WAY_W'(i) == w) begin
          ages_out[i*AGE_W +: AGE_W] = '0;
        end else if (ages_in[i*AGE_W +: AGE_W] < age_w) begin
          ages_out[i*AGE_W +: AGE_W] = ages_in[i*AGE_W +: AGE_W] + AGE_W'(1);
        end
      end
    end

    upd.wr_en          = hit_found || alloc;
    upd.lfsr_step      = victim && mode;
    upd.rsp.hit        = hit_found;
    upd.rsp.way        = (hit_found || alloc) ? WAY_OUT_W'(w) : '0;
    upd.rsp.fetch_line = alloc && (kind == REQ_READ || kind == REQ_WRITE);
    upd.rsp.evicted    = victim;
    upd.rsp.writeback  = victim && dirty_in[w];
    if (victim && dirty_in[w]) begin
      upd.rsp.writeback_address = (ADDR_W'(vic_tag) << (OFF_BITS + IDX_BITS))
                                | (ADDR_W'(index) << OFF_BITS);
    end
  end

endmodule

`default_nettype wire

>>> rtl/set_assoc_writeback_cache_directory.sv
`default_nettype none
// channel | dir | payload                                          | transfer when
// req     | in  | req_type, address                                | req.valid && req.ready
// rsp     | out | hit, way, fetch_line, writeback, wb address, evicted | rsp.valid && rsp.ready
// cfg     | in  | replacement_mode                                 | cfg.valid && cfg.ready
//
// each request is a read then a write: the set row is read from the directory memory
// on the accept edge and written back when the lookup completes, so the next request
// can only be taken after that write (read then write, no bypass between sets)
// the result sits in an output register; a new request is taken while it waits
// after reset a clearing pass writes every set with req.ready low
// a stalled rsp holds the lookup stage and its memory write until the slot frees
// SETS, WAYS and LINE_BYTES are powers of two

module set_assoc_writeback_cache_directory #(
  parameter int SETS       = scd_pkg::DEF_SETS,
  parameter int WAYS       = scd_pkg::DEF_WAYS,
  parameter int LINE_BYTES = scd_pkg::DEF_LINE_BYTES
) (
  input  var logic  clk,
  input  var logic  rst,
  scd_req_if.sink   req,
  scd_rsp_if.source rsp,
  scd_cfg_if.sink   cfg
);
  import scd_pkg::*;

  localparam int OFF_BITS = $clog2(LINE_BYTES);
  localparam int IDX_BITS = $clog2(SETS);
  localparam int IDX_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W    = ADDR_W - OFF_BITS - IDX_BITS;

  // one memory row holds a whole set: valid, dirty, tags, ages
  localparam int D_LO  = WAYS;
  localparam int T_LO  = 2 * WAYS;
  localparam int A_LO  = T_LO + WAYS * TAG_W;
  localparam int ROW_W = A_LO + WAYS * WAY_W;

  logic [ROW_W-1:0] dir_mem [SETS];
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] clear_row;
  logic [ROW_W-1:0] upd_row;
  logic [ROW_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_we;
  logic             mem_re;

  dir_state_t       state, state_next;
  logic [IDX_W-1:0] clr_cnt;
  logic             mode;
  logic [LFSR_W-1:0] lfsr;

  // request captured at accept
  req_kind_t        req_kind;
  logic [TAG_W-1:0] req_tag;
  logic [IDX_W-1:0] req_idx;
  logic [IDX_W-1:0] in_idx;

  logic             rsp_valid;
  result_t          rsp_data;
  logic             fire;

  logic [WAYS-1:0]        valid_new;
  logic [WAYS-1:0]        dirty_new;
  logic [WAYS*TAG_W-1:0]  tags_new;
  logic [WAYS*WAY_W-1:0]  ages_new;
  set_update_t            upd;

  // ---------------------------------------------------------------- handshakes
  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign mem_re    = req.valid && req.ready;
  // lookup completes once the output slot is free or being drained
  assign fire      = (state == ST_LOOKUP) && (!rsp_valid || rsp.ready);

  assign in_idx = IDX_W'((req.address >> OFF_BITS) & ADDR_W'(SETS - 1));

  // ------------------------------------------------------------- set update
  scd_set_update #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .LINE_BYTES (LINE_BYTES)
  ) u_set_update (
    .kind      (req_kind),
    .tag       (req_tag),
    .index     (req_idx),
    .mode      (mode),
    .lfsr      (lfsr),
    .valid_in  (rd_row[WAYS-1:0]),
    .dirty_in  (rd_row[D_LO +: WAYS]),
    .tags_in   (rd_row[T_LO +: WAYS*TAG_W]),
    .ages_in   (rd_row[A_LO +: WAYS*WAY_W]),
    .valid_out (valid_new),
    .dirty_out (dirty_new),
    .tags_out  (tags_new),
    .ages_out  (ages_new),
    .upd       (upd)
  );

  assign upd_row = {ages_new, tags_new, dirty_new, valid_new};

  // reset row: nothing valid, ages equal to way number
  always_comb begin
    clear_row = '0;
    for (int w = 0; w < WAYS; w++) begin
      clear_row[A_LO + w*WAY_W +: WAY_W] = WAY_W'(w);
    end
  end

  // -------------------------------------------------------- memory port mux
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = req_idx;
    mem_wdata = upd_row;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = clear_row;
    end else if (fire) begin
      mem_we = upd.wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dir_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row <= dir_mem[in_idx];
    end
  end

  // ----------------------------------------------------------- control fsm
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == IDX_W'(SETS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (mem_re) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (fire) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + IDX_W'(1);
      end
    end
  end

  // config register and lfsr; lfsr shifts right, feedback into the top bit
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      lfsr <= LFSR_SEED;
    end else begin
      if (cfg.valid && cfg.ready) begin
        mode <= cfg.replacement_mode;
      end
      if (fire && upd.lfsr_step) begin
        lfsr <= {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[LFSR_W-1:1]};
      end
    end
  end

  // request fields, payload only
  always_ff @(posedge clk) begin
    if (mem_re) begin
      req_kind <= req_kind_t'(req.req_type);
      req_tag  <= TAG_W'(req.address >> (OFF_BITS + IDX_BITS));
      req_idx  <= in_idx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_data <= upd.rsp;
    end
  end

  assign rsp.valid             = rsp_valid;
  assign rsp.hit               = rsp_data.hit;
  assign rsp.way               = rsp_data.way;
  assign rsp.fetch_line        = rsp_data.fetch_line;
  assign rsp.writeback         = rsp_data.writeback;
  assign rsp.writeback_address = rsp_data.writeback_address;
  assign rsp.evicted           = rsp_data.evicted;

  // ------------------------------------------------------------ assertions
  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == ST_LOOKUP))
    else $error("accepted request did not move to lookup");

  a_write_window: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR || state == ST_LOOKUP))
    else $error("directory written outside clear or lookup");

  a_lfsr_mode: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(lfsr)) |-> $past(mode))
    else $error("lfsr stepped in lru mode");

  a_wb_evict: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.writeback) |-> (rsp.evicted && !rsp.hit))
    else $error("writeback without eviction");

  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.evicted) |-> !rsp.hit)
    else $error("eviction reported on a hit");

endmodule

`default_nettype wire

>>> sim/set_assoc_writeback_cache_directory_tb.sv
module set_assoc_writeback_cache_directory_tb;
  import scd_pkg::*;

  // geometry of the block under test, default parameters
  localparam int SETS        = DEF_SETS;
  localparam int WAYS        = DEF_WAYS;
  localparam int LINE_BYTES  = DEF_LINE_BYTES;
  localparam int OFFSET_W    = $clog2(LINE_BYTES);
  localparam int INDEX_W     = $clog2(SETS);
  localparam int TAG_W       = ADDR_W - OFFSET_W - INDEX_W;
  localparam int HOT_SETS    = 4;
  localparam int HOT_TAGS    = 6;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SHOWN_ERRS  = 10;

  logic clk;
  logic rst;

  scd_req_if req_bus ();
  scd_rsp_if rsp_bus ();
  scd_cfg_if cfg_bus ();

  set_assoc_writeback_cache_directory uut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  // shadow copy of the directory: per-line valid, dirty, tag and age
  logic               line_valid [SETS][WAYS];
  logic               line_dirty [SETS][WAYS];
  logic [TAG_W-1:0]   line_tag   [SETS][WAYS];
  logic [1:0]         line_age   [SETS][WAYS];
  logic [LFSR_W-1:0]  lfsr_state;
  logic               repl_mode;

  // results still owed by the block, oldest first
  result_t pending_results [$];

  int  mismatch_count;
  int  cycle_count;
  bit  tx_idle_on;
  bit  rx_idle_on;
  int  hold_left;
  int  stall_left;

  // address pool that keeps traffic inside a few sets so lines hit and evict
  logic [INDEX_W-1:0] hot_sets [HOT_SETS];
  logic [TAG_W-1:0]   hot_tags [HOT_TAGS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // state after reset: everything invalid, age of way w is w
  function automatic void reset_directory_model();
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        line_valid[s][w] = 1'b0;
        line_dirty[s][w] = 1'b0;
        line_tag[s][w]   = '0;
        line_age[s][w]   = w[1:0];
      end
    end
    lfsr_state = LFSR_SEED;
    repl_mode  = 1'b0;
  endfunction

  // make way w most recent, ways younger than it age by one
  function automatic void promote_way(logic [INDEX_W-1:0] set_idx, int w);
    logic [1:0] old_age;
    old_age = line_age[set_idx][w];
    for (int i = 0; i < WAYS; i++) begin
      if (line_age[set_idx][i] < old_age) line_age[set_idx][i] = line_age[set_idx][i] + 2'd1;
    end
    line_age[set_idx][w] = 2'd0;
  endfunction

  // one lookup: works out the response and updates the shadow directory
  function automatic result_t predict_lookup(req_kind_t kind, logic [ADDR_W-1:0] addr);
    logic [INDEX_W-1:0] set_idx;
    logic [TAG_W-1:0]   tag_val;
    int                 w;
    bit                 found;
    bit                 free_found;
    logic               feedback;
    result_t            r;
    set_idx    = addr[OFFSET_W +: INDEX_W];
    tag_val    = addr[ADDR_W-1 -: TAG_W];
    r          = '0;
    w          = 0;
    found      = 1'b0;
    free_found = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      if (!found && line_valid[set_idx][i] && line_tag[set_idx][i] == tag_val) begin
        w     = i;
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (kind == REQ_INVAL) begin
        // dirty data is dropped, ages stay as they were
        line_valid[set_idx][w] = 1'b0;
        line_dirty[set_idx][w] = 1'b0;
      end else begin
        if (kind != REQ_READ) line_dirty[set_idx][w] = 1'b1;
        promote_way(set_idx, w);
      end
    end else if (kind != REQ_INVAL) begin
      // lowest invalid way first
      for (int i = 0; i < WAYS; i++) begin
        if (!free_found && !line_valid[set_idx][i]) begin
          w          = i;
          free_found = 1'b1;
        end
      end
      if (!free_found) begin
        if (repl_mode) begin
          // lfsr only steps when it picks a victim
          w          = lfsr_state % WAYS;
          feedback   = lfsr_state[0] ^ lfsr_state[2] ^ lfsr_state[3] ^ lfsr_state[5];
          lfsr_state = {feedback, lfsr_state[LFSR_W-1:1]};
        end else begin
          w = 0;
          for (int i = 1; i < WAYS; i++) begin
            if (line_age[set_idx][i] > line_age[set_idx][w]) w = i;
          end
        end
        r.evicted = 1'b1;
        if (line_dirty[set_idx][w]) begin
          r.writeback         = 1'b1;
          r.writeback_address = {line_tag[set_idx][w], set_idx, {OFFSET_W{1'b0}}};
        end
      end
      line_valid[set_idx][w] = 1'b1;
      line_tag[set_idx][w]   = tag_val;
      line_dirty[set_idx][w] = (kind != REQ_READ);
      r.fetch_line           = (kind == REQ_READ || kind == REQ_WRITE);
      promote_way(set_idx, w);
    end
    if (found || kind != REQ_INVAL) r.way = w[WAY_OUT_W-1:0];
    return r;
  endfunction

  // mostly no gap, sometimes a short one, rarely a long one
  function automatic int idle_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ADDR_W-1:0] make_addr(logic [TAG_W-1:0] tag_val,
                                                  logic [INDEX_W-1:0] set_idx,
                                                  logic [OFFSET_W-1:0] offset);
    return {tag_val, set_idx, offset};
  endfunction

  function automatic void refresh_hot_pool();
    for (int i = 0; i < HOT_SETS; i++) hot_sets[i] = INDEX_W'($urandom_range(0, SETS - 1));
    for (int i = 0; i < HOT_TAGS; i++) hot_tags[i] = TAG_W'($urandom);
  endfunction

  // reads dominate, invalidates keep some ways free
  function automatic req_kind_t pick_kind();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return REQ_READ;
    if (roll < 7) return REQ_WRITE;
    if (roll < 8) return REQ_INSTALL;
    return REQ_INVAL;
  endfunction

  // most addresses come from the hot pool, the rest anywhere in the space
  function automatic logic [ADDR_W-1:0] pick_address();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return make_addr(hot_tags[$urandom_range(0, HOT_TAGS - 1)],
                     hot_sets[$urandom_range(0, HOT_SETS - 1)],
                     OFFSET_W'($urandom_range(0, LINE_BYTES - 1)));
  endfunction

  // scoreboard: responses are checked before the same edge's request is predicted
  always @(posedge clk) begin
    result_t got;
    result_t want;
    logic [5:0] diff;
    if (!rst) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        got.hit               = rsp_bus.hit;
        got.way               = rsp_bus.way;
        got.fetch_line        = rsp_bus.fetch_line;
        got.writeback         = rsp_bus.writeback;
        got.writeback_address = rsp_bus.writeback_address;
        got.evicted           = rsp_bus.evicted;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_ERRS)
            $display("unexpected response transfer at cycle %0d: hit=%b way=%0d", cycle_count,
                     got.hit, got.way);
        end else begin
          want = pending_results.pop_front();
          diff = {got.hit !== want.hit, got.way !== want.way,
                  got.fetch_line !== want.fetch_line, got.writeback !== want.writeback,
                  got.writeback_address !== want.writeback_address,
                  got.evicted !== want.evicted};
          if (diff != '0) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_ERRS) begin
              $display("mismatch at cycle %0d (hit way fetch wb wb_addr ev: %b)",
                       cycle_count, diff);
              $display("  expected %b %0d %b %b %h %b", want.hit, want.way,
                       want.fetch_line, want.writeback, want.writeback_address,
                       want.evicted);
              $display("  actual   %b %0d %b %b %h %b", got.hit, got.way,
                       got.fetch_line, got.writeback, got.writeback_address,
                       got.evicted);
            end
          end
        end
      end
      if (req_bus.valid && req_bus.ready)
        pending_results.push_back(predict_lookup(req_kind_t'(req_bus.req_type),
                                                 req_bus.address));
      if (cfg_bus.valid && cfg_bus.ready) repl_mode = cfg_bus.replacement_mode;
    end
  end

  // cycle watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL set_assoc_writeback_cache_directory");
      $finish;
    end
  end

  // response side: a long hold-off takes priority over the usual random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_bus.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (stall_left > 0) begin
      rsp_bus.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      rsp_bus.ready <= 1'b1;
      if (rx_idle_on && $urandom_range(0, 3) == 0) stall_left = idle_length();
    end
  end

  // called at a falling edge; returns at a falling edge after the transfer
  task automatic send_request(req_kind_t kind, logic [ADDR_W-1:0] addr);
    int gap;
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.address  <= addr;
    do @(posedge clk); while (!req_bus.ready);
    @(negedge clk);
    gap = tx_idle_on ? idle_length() : 0;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // stop offering requests and let every owed response come back
  task automatic drain_requests();
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // register writes only happen with the block empty
  task automatic write_replacement_mode(logic mode);
    drain_requests();
    cfg_bus.valid            <= 1'b1;
    cfg_bus.replacement_mode <= mode;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_random_traffic(int count, bit allow_idle);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) refresh_hot_pool();
      // reroll idling now and then, leaving some stretches with none
      if (i % 100 == 0) begin
        tx_idle_on = allow_idle && ($urandom_range(0, 3) != 0);
        rx_idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      end
      send_request(pick_kind(), pick_address());
    end
  endtask

  // address extremes, every request kind, fills, lru evictions clean and dirty
  task automatic test_directed_lru();
    write_replacement_mode(1'b0);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_request(REQ_READ,    32'h0000_0000);                      // cold miss, way 0
    send_request(REQ_READ,    32'h0000_0000);                      // read hit
    send_request(REQ_WRITE,   32'hFFFF_FFFF);                      // write miss, top set
    send_request(REQ_INVAL,   32'h1234_5000);                      // invalidate miss
    send_request(REQ_INSTALL, make_addr(20'h00001, 6'd0, 6'h00));  // install miss
    send_request(REQ_WRITE,   make_addr(20'h00002, 6'd0, 6'h04));
    send_request(REQ_INSTALL, make_addr(20'h00001, 6'd0, 6'h10));  // install hit
    send_request(REQ_READ,    make_addr(20'h00003, 6'd0, 6'h3F));  // set 0 now full
    send_request(REQ_READ,    make_addr(20'h00004, 6'd0, 6'h00));  // clean lru victim
    send_request(REQ_READ,    make_addr(20'h00005, 6'd0, 6'h00));  // dirty victim
    send_request(REQ_INVAL,   make_addr(20'h00002, 6'd0, 6'h08));  // invalidate miss, line already evicted
    send_request(REQ_READ,    make_addr(20'h00006, 6'd0, 6'h00));  // dirty lru victim
    send_request(REQ_WRITE,   32'hFFFF_FFC0);                      // write hit
    send_request(REQ_INVAL,   32'hFFFF_FFFF);                      // invalidate hit
    send_request(REQ_INSTALL, 32'hFFFF_FFFF);                      // install after inval
  endtask

  task automatic test_lru_traffic();
    run_random_traffic(450, 1'b1);
  endtask

  // response side holds off while requests keep coming, so the input stalls
  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    refresh_hot_pool();
    hold_left = 300;
    for (int i = 0; i < 80; i++) send_request(pick_kind(), pick_address());
  endtask

  // fill one set with dirty lines, then force lfsr victims
  task automatic test_lfsr_replacement();
    write_replacement_mode(1'b1);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int i = 0; i < 4; i++)
      send_request(REQ_WRITE, make_addr(TAG_W'(20'hA0000 + i), 6'd9, 6'h00));
    for (int i = 0; i < 4; i++)
      send_request(REQ_READ, make_addr(TAG_W'(20'h50000 + i), 6'd9, 6'h20));
    run_random_traffic(450, 1'b1);
  endtask

  // back to lru with ages left by random mode
  task automatic test_mode_return();
    write_replacement_mode(1'b0);
    run_random_traffic(350, 1'b1);
  endtask

  initial begin
    rst                      = 1'b1;
    req_bus.valid            = 1'b0;
    req_bus.req_type         = REQ_READ;
    req_bus.address          = '0;
    rsp_bus.ready            = 1'b0;
    cfg_bus.valid            = 1'b0;
    cfg_bus.replacement_mode = 1'b0;
    mismatch_count           = 0;
    cycle_count              = 0;
    hold_left                = 0;
    stall_left               = 0;
    tx_idle_on               = 1'b0;
    rx_idle_on               = 1'b0;
    reset_directory_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_lru();
    test_lru_traffic();
    test_output_backpressure();
    test_lfsr_replacement();
    test_mode_return();

    drain_requests();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS set_assoc_writeback_cache_directory");
    end else begin
      $display("FAIL set_assoc_writeback_cache_directory");
    end
    $finish;
  end

endmodule
